// ===== sv/fa2_pkg.sv =====
// Shared types and constants for the fast atan2 approximation block.
// No dependencies; imported by fa2_div and fast_atan2_approximation.
package fa2_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

   // magnitude of a coordinate fits COORD_WIDTH unsigned bits (2^(W-1) at most)
   localparam int MAG_WIDTH  = COORD_WIDTH;
   localparam int PROD_WIDTH = 2 * COORD_WIDTH - 1;
   localparam int DEN_WIDTH  = PROD_WIDTH;
   // quotient reaches 2^F when both magnitudes are one
   localparam int QUO_WIDTH  = ANGLE_FRAC_BITS + 1;

   localparam int COEF_WIDTH = 15;
   localparam logic [COEF_WIDTH-1:0] COEF_Q16 = 15'd18350;

   localparam longint unsigned PI_Q32 = 64'd13493037705;
   localparam int PI_Q  = int'((PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
                               >> (32 - ANGLE_FRAC_BITS));
   localparam int PIH_Q = int'((PI_Q32 + (64'd1 << (32 - ANGLE_FRAC_BITS)))
                               >> (33 - ANGLE_FRAC_BITS));

   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic x_neg;
      logic y_neg;
      logic y_lt_x;   // |y| < |x|: octant near the x axis
   } fa2_ctl_type;

endpackage

// ===== sv/fa2_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, QUO_WIDTH stages.
// Carries the item's control flags alongside. Depends on fa2_pkg.
module fa2_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [fa2_pkg::PROD_WIDTH-1:0]   in_prod,
   input  logic [fa2_pkg::DEN_WIDTH-1:0]    in_den,
   input  fa2_pkg::fa2_ctl_type             in_ctl,
   output logic                             out_valid,
   output logic [fa2_pkg::QUO_WIDTH-1:0]    out_quo,
   output fa2_pkg::fa2_ctl_type             out_ctl
);
   import fa2_pkg::*;

   logic                 valid_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0] rem_ff   [QUO_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff   [QUO_WIDTH];
   logic [QUO_WIDTH-1:0] quo_ff   [QUO_WIDTH];
   fa2_ctl_type          ctl_ff   [QUO_WIDTH];

   genvar i;
   generate
      for (i = 0; i < QUO_WIDTH; i++) begin : g_step
         logic                 prev_valid;
         logic [DEN_WIDTH-1:0] prev_rem;
         logic [DEN_WIDTH-1:0] prev_den;
         logic [QUO_WIDTH-1:0] prev_quo;
         fa2_ctl_type          prev_ctl;
         logic                 shift_bit;
         logic [DEN_WIDTH:0]   trial;
         logic                 take;
         logic [DEN_WIDTH-1:0] rem_in;
         logic [QUO_WIDTH-1:0] quo_in;

         if (i == 0) begin : g_first
            // dividend is prod * 2^F: start from prod/2, bring in its low bit first
            assign prev_valid = in_valid;
            assign prev_rem   = DEN_WIDTH'(in_prod >> 1);
            assign prev_den   = in_den;
            assign prev_quo   = '0;
            assign prev_ctl   = in_ctl;
            assign shift_bit  = in_prod[0];
         end else begin : g_next
            assign prev_valid = valid_ff[i-1];
            assign prev_rem   = rem_ff[i-1];
            assign prev_den   = den_ff[i-1];
            assign prev_quo   = quo_ff[i-1];
            assign prev_ctl   = ctl_ff[i-1];
            assign shift_bit  = 1'b0;
         end

         always_comb begin
            trial  = {prev_rem, shift_bit};
            take   = trial >= {1'b0, prev_den};
            rem_in = take ? DEN_WIDTH'(trial - {1'b0, prev_den}) : trial[DEN_WIDTH-1:0];
            quo_in = {prev_quo[QUO_WIDTH-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= prev_valid;
            end
            if (en) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= prev_den;
               quo_ff[i] <= quo_in;
               ctl_ff[i] <= prev_ctl;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign out_quo   = quo_ff[QUO_WIDTH-1];
   assign out_ctl   = ctl_ff[QUO_WIDTH-1];

endmodule

// ===== sv/fast_atan2_approximation.sv =====
// Fast atan2 approximation, rational form with the 0.28 coefficient.
// Channels: req_ beats carry a (y, x) pair, rsp_ beats carry the angle in
// radians, signed Q3.13, saturated to +/-pi. Each request beat gives exactly
// one response beat, in order.
// Throughput: one beat per cycle while the receiver does not stall. The
// pipeline is 20 register stages (select, three multiply/add stages, 14
// divider stages, two angle stages) plus the output register.
// The 14-stage divider produces one quotient bit per stage.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; the pipeline then freezes and req_tready
// drops until the skid register drains. Nothing is lost or repeated.
// Reset clears all valid bits; the block keeps no other state and is ready
// for a beat in the first cycle after reset.
// Depends on fa2_pkg and fa2_div.
module fast_atan2_approximation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] y_coord, [31:16] x_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] angle
);
   import fa2_pkg::*;

   localparam int ANG_EXT = ANGLE_WIDTH + 2;
   localparam logic signed [ANG_EXT-1:0] PI_X      = ANG_EXT'(PI_Q);
   localparam logic signed [ANG_EXT-1:0] PIH_X     = ANG_EXT'(PIH_Q);
   localparam logic signed [ANG_EXT-1:0] PIH_M_PI  = ANG_EXT'(PIH_Q - PI_Q);
   localparam int COEF_PROD = COEF_WIDTH + PROD_WIDTH;

   logic en;
   logic skid_valid_ff;
   logic [ANGLE_WIDTH-1:0] skid_data_ff;
   logic out_valid_ff;
   logic [ANGLE_WIDTH-1:0] out_data_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // stage 1: magnitudes, octant, operand select
   logic signed [COORD_WIDTH-1:0] y_in, x_in;
   logic [MAG_WIDTH-1:0] ay, ax;
   fa2_ctl_type ctl_in;
   logic s1_valid_ff;
   logic [MAG_WIDTH-1:0] a_ff, b_ff;
   fa2_ctl_type s1_ctl_ff;

   always_comb begin
      y_in = $signed(req_tdata[COORD_WIDTH-1:0]);
      x_in = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
      ay   = y_in[COORD_WIDTH-1] ? MAG_WIDTH'(-y_in) : MAG_WIDTH'(y_in);
      ax   = x_in[COORD_WIDTH-1] ? MAG_WIDTH'(-x_in) : MAG_WIDTH'(x_in);
      ctl_in.x_zero = (x_in == '0);
      ctl_in.y_zero = (y_in == '0);
      ctl_in.x_neg  = x_in[COORD_WIDTH-1];
      ctl_in.y_neg  = y_in[COORD_WIDTH-1];
      ctl_in.y_lt_x = ay < ax;
   end

   // stage 2: products; stage 3: coefficient; stage 4: denominator
   logic s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [PROD_WIDTH-1:0] s2_ab_ff, s2_bb_ff, s2_aa_ff;
   logic [PROD_WIDTH-1:0] s3_ab_ff, s3_bb_ff, s3_coef_ff;
   logic [PROD_WIDTH-1:0] s4_ab_ff;
   logic [DEN_WIDTH-1:0]  s4_den_ff;
   fa2_ctl_type s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [COEF_PROD-1:0]  coef_full;

   assign coef_full = COEF_PROD'(COEF_Q16) * COEF_PROD'(s2_aa_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         a_ff       <= ctl_in.y_lt_x ? ay : ax;
         b_ff       <= ctl_in.y_lt_x ? ax : ay;
         s1_ctl_ff  <= ctl_in;
         s2_ab_ff   <= PROD_WIDTH'(a_ff * b_ff);
         s2_bb_ff   <= PROD_WIDTH'(b_ff * b_ff);
         s2_aa_ff   <= PROD_WIDTH'(a_ff * a_ff);
         s2_ctl_ff  <= s1_ctl_ff;
         s3_ab_ff   <= s2_ab_ff;
         s3_bb_ff   <= s2_bb_ff;
         s3_coef_ff <= PROD_WIDTH'(coef_full >> 16);
         s3_ctl_ff  <= s2_ctl_ff;
         s4_ab_ff   <= s3_ab_ff;
         s4_den_ff  <= DEN_WIDTH'(s3_bb_ff + s3_coef_ff);
         s4_ctl_ff  <= s3_ctl_ff;
      end
   end

   logic div_valid;
   logic [QUO_WIDTH-1:0] div_quo;
   fa2_ctl_type div_ctl;

   fa2_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_prod   (s4_ab_ff),
      .in_den    (s4_den_ff),
      .in_ctl    (s4_ctl_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ctl   (div_ctl)
   );

   // angle stage: sign the ratio, add the quadrant offset
   logic signed [ANG_EXT-1:0] ratio, ang_in;
   logic f1_valid_ff, f2_valid_ff;
   logic signed [ANG_EXT-1:0] f1_ang_ff;
   logic [ANGLE_WIDTH-1:0] f2_ang_ff, sat_in;

   always_comb begin
      ratio = $signed(ANG_EXT'(div_quo));
      if (div_ctl.x_neg ^ div_ctl.y_neg) begin
         ratio = -ratio;
      end
      if (div_ctl.x_zero) begin
         if (div_ctl.y_zero) begin
            ang_in = '0;
         end else if (div_ctl.y_neg) begin
            ang_in = -PIH_X;
         end else begin
            ang_in = PIH_X;
         end
      end else if (div_ctl.y_lt_x) begin
         if (!div_ctl.x_neg) begin
            ang_in = ratio;
         end else if (div_ctl.y_neg) begin
            ang_in = ratio - PI_X;
         end else begin
            ang_in = ratio + PI_X;
         end
      end else if (div_ctl.y_neg) begin
         ang_in = PIH_M_PI - ratio;
      end else begin
         ang_in = PIH_X - ratio;
      end
   end

   // clamp to +/-pi
   always_comb begin
      if (f1_ang_ff > PI_X) begin
         sat_in = ANGLE_WIDTH'(PI_X);
      end else if (f1_ang_ff < -PI_X) begin
         sat_in = ANGLE_WIDTH'(-PI_X);
      end else begin
         sat_in = f1_ang_ff[ANGLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= div_valid;
         f2_valid_ff <= f1_valid_ff;
      end
      if (en) begin
         f1_ang_ff <= ang_in;
         f2_ang_ff <= sat_in;
      end
   end

   // output register with skid: the skid slot catches the beat that leaves
   // the pipeline in the cycle the receiver stalls
   logic out_take;
   assign out_take = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (f2_valid_ff) begin
         if (out_take) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= f2_ang_ff;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= f2_ang_ff;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_only_when_stalled: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("skid filled while output was free");

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid)
      else $error("skid holds a beat while output register is empty");

   // x on the axis leaves the quotient unused (zero denominator at the origin)
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      (div_valid && !div_ctl.x_zero) |-> div_quo <= QUO_WIDTH'(1 << ANGLE_FRAC_BITS))
      else $error("divider quotient out of range");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= PI_X) && ($signed(rsp_tdata) >= -PI_X))
      else $error("angle beyond +/-pi");

endmodule

// ===== verif/fast_atan2_approximation_tb.sv =====
// Self-checking testbench for fast_atan2_approximation: streams (y, x) pairs
// and compares every angle beat against a built-in fixed-point predictor.
// Depends on fa2_pkg and the fast_atan2_approximation RTL only.
module fast_atan2_approximation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fa2_pkg::*;

   localparam int FRAC                     = 13;
   localparam longint unsigned PI_2POW32   = 64'd13493037705;
   localparam longint PI_FIX               = longint'((PI_2POW32 + (64'd1 << (31 - FRAC)))
                                                      >> (32 - FRAC));
   localparam longint HALF_PI_FIX          = longint'((PI_2POW32 + (64'd1 << (32 - FRAC)))
                                                      >> (33 - FRAC));
   localparam longint unsigned K028_Q16    = 64'd18350;
   localparam int RANDOM_PAIRS             = 1400;
   localparam int LONG_HOLD_CYCLES         = 300;
   localparam int LONG_HOLD_AT_BEAT        = 300;
   localparam int IDLE_LIMIT               = 2000;
   localparam int DRAIN_CYCLES             = 40;

   class angle_scoreboard;
      logic [ANGLE_WIDTH-1:0] pending_angles[$];
      logic [31:0]            pending_pairs[$];
      int                     errors;
      int                     checked;

      function new();
         errors  = 0;
         checked = 0;
      endfunction

      // |a*b| / (b^2 + 0.28 a^2) with FRAC fraction bits, truncated
      function longint unsigned ratio_fix(longint unsigned a, longint unsigned b);
         longint unsigned num;
         longint unsigned den;
         while (b >= 64'd65536) begin
            a = a >> 1;
            b = b >> 1;
         end
         num = (a * b) << FRAC;
         den = b * b + ((K028_Q16 * a * a) >> 16);
         if (den == 0)
            return 0;
         return num / den;
      endfunction

      function logic [ANGLE_WIDTH-1:0] predict_angle(logic signed [15:0] y,
                                                     logic signed [15:0] x);
         longint sy;
         longint sx;
         longint ay;
         longint ax;
         longint r;
         longint ang;
         bit     opposite;
         sy = y;
         sx = x;
         ay = (sy < 0) ? -sy : sy;
         ax = (sx < 0) ? -sx : sx;
         opposite = (sx < 0) != (sy < 0);
         if (sx == 0) begin
            ang = (sy > 0) ? HALF_PI_FIX : ((sy == 0) ? 0 : -HALF_PI_FIX);
         end else if (ay < ax) begin
            r = longint'(ratio_fix(ay, ax));
            if (opposite)
               r = -r;
            ang = r;
            if (sx < 0)
               ang = (sy < 0) ? r - PI_FIX : r + PI_FIX;
         end else begin
            r = longint'(ratio_fix(ax, ay));
            if (opposite)
               r = -r;
            ang = HALF_PI_FIX - r;
            if (sy < 0)
               ang = ang - PI_FIX;
         end
         if (ang > PI_FIX)
            ang = PI_FIX;
         if (ang < -PI_FIX)
            ang = -PI_FIX;
         return ang[ANGLE_WIDTH-1:0];
      endfunction

      function void note_pair(logic [31:0] pair);
         pending_angles.push_back(predict_angle(pair[15:0], pair[31:16]));
         pending_pairs.push_back(pair);
      endfunction

      function void check_angle(logic [ANGLE_WIDTH-1:0] actual);
         logic [ANGLE_WIDTH-1:0] want;
         logic [31:0]            pair;
         if (pending_angles.size() == 0) begin
            $error("angle: expected no beat, got %0d", $signed(actual));
            errors++;
            return;
         end
         want = pending_angles.pop_front();
         pair = pending_pairs.pop_front();
         checked++;
         if (actual !== want) begin
            $error("angle: expected %0d, got %0d (y=%0d x=%0d)", $signed(want),
                   $signed(actual), $signed(pair[15:0]), $signed(pair[31:16]));
            errors++;
         end
      endfunction

      function int pending();
         return pending_angles.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [15:0] y_coord, [31:16] x_coord
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] angle

   angle_scoreboard angles;
   bit              sender_no_idle   = 1'b0;
   int              pairs_sent       = 0;

   fast_atan2_approximation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_pair(logic signed [15:0] y, logic signed [15:0] x);
      int gap;
      gap = sender_no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {x, y};
      do @(posedge clock); while (req_tready !== 1'b1);
      angles.note_pair({x, y});
      pairs_sent++;
   endtask

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 16'sh8000;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         default: return 16'sh7fff;
      endcase
   endfunction

   task automatic send_random_pair();
      logic signed [15:0] y;
      logic signed [15:0] x;
      int                 kind;
      kind = $urandom_range(0, 9);
      x = 16'($urandom);
      y = 16'($urandom);
      case (kind)
         4, 5: begin
            // small magnitudes exercise truncation of the quotient
            y = 16'(int'($urandom_range(0, 16)) - 8);
            x = 16'(int'($urandom_range(0, 16)) - 8);
         end
         6, 7: begin
            // straddle the |y| = |x| branch boundary
            y = $urandom_range(0, 1) ? x : -x;
            y = y + 16'(int'($urandom_range(0, 4)) - 2);
         end
         8: begin
            if ($urandom_range(0, 1))
               x = $urandom_range(0, 1) ? 16'sd0 : 16'sh8000;
            else
               y = $urandom_range(0, 1) ? 16'sd0 : 16'sh8000;
         end
         9: begin
            y = pick_extreme();
            x = pick_extreme();
         end
         default: ;
      endcase
      send_pair(y, x);
   endtask

   // response side: random back-pressure plus one long hold-off
   initial begin
      int stall;
      bit held_off;
      held_off = 1'b0;
      angles = new();
      @(negedge reset);
      forever begin
         if (!held_off && angles.checked == LONG_HOLD_AT_BEAT) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            // no back-pressure for a stretch in the middle of the run
            stall = (angles.checked >= 800 && angles.checked < 1000) ? 0 :
                    $urandom_range(0, 6);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         angles.check_angle(rsp_tdata);
      end
   end

   // end the run if no beat moves on either side for too long
   initial begin
      int idle;
      idle = 0;
      @(negedge reset);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // axes, origin and full-scale corners
      send_pair(16'sd0, 16'sd0);
      send_pair(16'sd1, 16'sd0);
      send_pair(-16'sd1, 16'sd0);
      send_pair(16'sh7fff, 16'sd0);
      send_pair(16'sh8000, 16'sd0);
      send_pair(16'sd0, 16'sd1);
      send_pair(16'sd0, -16'sd1);
      send_pair(16'sd0, 16'sh7fff);
      send_pair(16'sd0, 16'sh8000);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'sh8000, 16'sh7fff);
      // diagonal: equal magnitudes take the steep branch
      send_pair(16'sd1, 16'sd1);
      send_pair(-16'sd1, -16'sd1);
      send_pair(16'sd1, -16'sd1);
      send_pair(-16'sd1, 16'sd1);
      // shallow branch in the left half plane, both signs of y
      send_pair(16'sd5, -16'sd7);
      send_pair(-16'sd5, -16'sd7);
      send_pair(-16'sd1, 16'sh8000);
      send_pair(16'sd1, 16'sh8000);
      // steep branch, all sign combinations
      send_pair(16'sd7, 16'sd5);
      send_pair(-16'sd7, 16'sd5);
      send_pair(-16'sd7, -16'sd5);
      send_pair(16'sd7, -16'sd5);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         sender_no_idle = (i >= 400 && i < 600);
         send_random_pair();
      end
      req_tvalid <= 1'b0;

      while (angles.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d coordinate pairs (axes, diagonals, extremes, random) and checked %0d",
               pairs_sent, angles.checked);
      $display("angle beats under random idling and a %0d-cycle output hold-off.",
               LONG_HOLD_CYCLES);
      if (angles.errors == 0 && angles.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fa2_pkg.sv
sv/fa2_div.sv
sv/fast_atan2_approximation.sv
verif/fast_atan2_approximation_tb.sv
